// ----- hw/rtl/bol_pkg.sv -----
`default_nettype none

package bol_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int DATA_W    = 32;
    localparam int CMD_W     = 4;
    localparam int POS_W     = 5;
    localparam int AMT_W     = 16;
    localparam int CNT_OUT_W = 5;

    localparam logic [CMD_W-1:0] CMD_INS_FRONT = 4'd0;
    localparam logic [CMD_W-1:0] CMD_INS_END   = 4'd1;
    localparam logic [CMD_W-1:0] CMD_INS_POS   = 4'd2;
    localparam logic [CMD_W-1:0] CMD_DEL_FRONT = 4'd3;
    localparam logic [CMD_W-1:0] CMD_DEL_END   = 4'd4;
    localparam logic [CMD_W-1:0] CMD_DEL_POS   = 4'd5;
    localparam logic [CMD_W-1:0] CMD_SEARCH    = 4'd6;
    localparam logic [CMD_W-1:0] CMD_ROTATE    = 4'd7;
    localparam logic [CMD_W-1:0] CMD_DUMP      = 4'd8;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_INVALID  = 3'd3,
        ST_NOTFOUND = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD,
        S_COPY,
        S_FIX,
        S_SEARCH,
        S_DUMP_RD,
        S_DUMP_WAIT,
        S_RESP
    } state_t;

    typedef struct packed {
        logic [CMD_W-1:0]         cmd;
        logic signed [DATA_W-1:0] data_value;
        logic [POS_W-1:0]         position;
        logic [AMT_W-1:0]         rotate_amount;
    } bol_req_t;

    typedef struct packed {
        logic [2:0]               status;
        logic [POS_W-1:0]         found_position;
        logic signed [DATA_W-1:0] element_value;
        logic [CNT_OUT_W-1:0]     element_count;
        logic                     last_of_run;
    } bol_rsp_t;

endpackage

`default_nettype wire

// ----- hw/rtl/bol_mem.sv -----
`default_nettype none

module bol_mem #(
    parameter int DEPTH = bol_pkg::DEPTH_DEF,
    parameter int AW    = 4
) (
    input  logic                      clk,
    input  logic                      wr_en,
    input  logic [AW-1:0]             wr_addr,
    input  logic [bol_pkg::DATA_W-1:0] wr_data,
    input  logic                      rd_en,
    input  logic [AW-1:0]             rd_addr,
    output logic [bol_pkg::DATA_W-1:0] rd_data
);

    logic [bol_pkg::DATA_W-1:0] mem [DEPTH];
    logic [bol_pkg::DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/bol_mod.sv -----
`default_nettype none

module bol_mod #(
    parameter int CW = 5
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [bol_pkg::AMT_W-1:0] dividend,
    input  logic [CW-1:0]             divisor,
    output logic                      done,
    output logic [CW-1:0]             rem
);

    localparam int DW = bol_pkg::AMT_W;
    localparam int NW = $clog2(DW + 1);

    logic          busy_reg;
    logic [NW-1:0] cnt_reg;
    logic [DW-1:0] sh_reg;
    logic [CW-1:0] rem_reg;
    logic [CW:0]   trial;
    logic          ge;

    // restoring remainder, one dividend bit a cycle
    assign trial = {rem_reg, sh_reg[DW-1]};
    assign ge    = (trial >= (CW+1)'(divisor));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= NW'(DW);
        end
        else if (busy_reg)
        begin
            if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - NW'(1);
            end
            else
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            sh_reg  <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg && (cnt_reg != '0))
        begin
            sh_reg  <= {sh_reg[DW-2:0], 1'b0};
            rem_reg <= ge ? CW'(trial - (CW+1)'(divisor)) : CW'(trial);
        end
    end

    assign done = busy_reg && (cnt_reg == '0);
    assign rem  = rem_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/bounded_ordered_list.sv -----
`default_nettype none

// Bounded ordered list of up to DEPTH signed 32-bit words, held as a circular
// buffer in one single-port-read, single-port-write RAM with a head pointer.
// A command is taken only while the sequencer is idle; each gives one response
// word, except a dump of a non-empty list, which gives one word per entry with
// last_of_run on the final one. A command that fails its checks goes straight
// to the response. Positional insert and delete move entries through the RAM
// one per cycle. Search reads one entry a cycle from the head until a match or
// the end of the list. Rotate runs a bit-serial remainder of the amount by the
// entry count, then moves k entries one per cycle, k being that remainder. Dump
// reads each entry through the RAM's registered read and waits on the response
// side before the next read. The response register lets a finished word wait
// while the next command is already being worked on.
module bounded_ordered_list #(
    parameter int DEPTH = bol_pkg::DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  bol_pkg::bol_req_t req,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output bol_pkg::bol_rsp_t rsp
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;
    localparam int XW = SW + 1;
    localparam int LW = (SW > bol_pkg::POS_W) ? SW : bol_pkg::POS_W;
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                               input logic [SW-1:0] off);
        logic [XW-1:0] s;
        s = XW'(base) + XW'(off);
        if (s >= XW'(DEPTH))
        begin
            s = s - XW'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == LAST_ADDR) ? '0 : p + AW'(1);
    endfunction

    function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
        return (p == '0) ? LAST_ADDR : p - AW'(1);
    endfunction

    bol_pkg::state_t  state_reg, state_next;
    logic [AW-1:0]    head_reg, head_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [bol_pkg::CMD_W-1:0]  op_reg, op_next;
    logic [bol_pkg::DATA_W-1:0] val_reg, val_next;
    logic [SW-1:0]    idx_reg, idx_next;
    logic [AW-1:0]    src_ptr_reg, src_ptr_next;
    logic [AW-1:0]    dst_ptr_reg, dst_ptr_next;
    logic [AW-1:0]    pend_dst_reg, pend_dst_next;
    logic             up_reg, up_next;
    logic [CW-1:0]    left_reg, left_next;
    logic             wr_pend_reg, wr_pend_next;
    logic             chk_reg, chk_next;
    logic [CW-1:0]    rd_cnt_reg, rd_cnt_next;
    bol_pkg::status_t status_reg, status_next;
    logic [bol_pkg::POS_W-1:0] fpos_reg, fpos_next;
    logic             rsp_valid_reg, rsp_valid_next;
    bol_pkg::bol_rsp_t rsp_reg, rsp_next;

    logic                       mem_wr_en;
    logic [AW-1:0]              mem_wr_addr;
    logic [bol_pkg::DATA_W-1:0] mem_wr_data;
    logic                       mem_rd_en;
    logic [AW-1:0]              mem_rd_addr;
    logic [bol_pkg::DATA_W-1:0] mem_rd_data;

    logic          mod_start;
    logic          mod_done;
    logic [CW-1:0] mod_rem;

    logic          accept;
    logic          rsp_free;
    logic          full;
    logic          empty;
    logic [LW-1:0] pos_w;
    logic [LW-1:0] cnt_w;
    logic [SW-1:0] idx_s;
    logic [AW-1:0] tail_phys;
    logic [AW-1:0] idx_phys;
    logic [AW-1:0] fix_phys;

    bol_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    bol_mod #(
        .CW (CW)
    ) u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (req.rotate_amount),
        .divisor  (count_reg),
        .done     (mod_done),
        .rem      (mod_rem)
    );

    assign req_ready = (state_reg == bol_pkg::S_IDLE);
    assign accept    = req_valid && req_ready;
    assign rsp_free  = !rsp_valid_reg || rsp_ready;
    assign full      = (count_reg == FULL_CNT);
    assign empty     = (count_reg == '0);
    assign pos_w     = LW'(req.position);
    assign cnt_w     = LW'(count_reg);
    assign idx_s     = SW'(pos_w - LW'(1));
    assign tail_phys = wrap_add(head_reg, SW'(count_reg));
    assign idx_phys  = wrap_add(head_reg, idx_s);
    assign fix_phys  = wrap_add(head_reg, idx_reg);

    always_comb
    begin
        state_next    = state_reg;
        head_next     = head_reg;
        count_next    = count_reg;
        op_next       = op_reg;
        val_next      = val_reg;
        idx_next      = idx_reg;
        src_ptr_next  = src_ptr_reg;
        dst_ptr_next  = dst_ptr_reg;
        pend_dst_next = pend_dst_reg;
        up_next       = up_reg;
        left_next     = left_reg;
        wr_pend_next  = wr_pend_reg;
        chk_next      = chk_reg;
        rd_cnt_next   = rd_cnt_reg;
        status_next   = status_reg;
        fpos_next     = fpos_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_next      = rsp_reg;
        mem_wr_en     = 1'b0;
        mem_wr_addr   = pend_dst_reg;
        mem_wr_data   = mem_rd_data;
        mem_rd_en     = 1'b0;
        mem_rd_addr   = src_ptr_reg;
        mod_start     = 1'b0;

        case (state_reg)
            bol_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    op_next      = req.cmd;
                    val_next     = req.data_value;
                    idx_next     = idx_s;
                    fpos_next    = '0;
                    status_next  = bol_pkg::ST_OK;
                    left_next    = '0;
                    wr_pend_next = 1'b0;
                    chk_next     = 1'b0;
                    rd_cnt_next  = '0;
                    state_next   = bol_pkg::S_RESP;
                    case (req.cmd)
                        bol_pkg::CMD_INS_FRONT,
                        bol_pkg::CMD_INS_END:
                        begin
                            if (full)
                            begin
                                status_next = bol_pkg::ST_FULL;
                            end
                            else
                            begin
                                state_next = bol_pkg::S_FIX;
                            end
                        end
                        bol_pkg::CMD_INS_POS:
                        begin
                            if (full || (pos_w == '0) || (pos_w > cnt_w + LW'(1)))
                            begin
                                status_next = bol_pkg::ST_INVALID;
                            end
                            else
                            begin
                                // open the gap from the tail downwards
                                left_next    = CW'(SW'(count_reg) - idx_s);
                                dst_ptr_next = tail_phys;
                                src_ptr_next = ptr_dec(tail_phys);
                                up_next      = 1'b0;
                                state_next   = bol_pkg::S_COPY;
                            end
                        end
                        bol_pkg::CMD_DEL_FRONT,
                        bol_pkg::CMD_DEL_END:
                        begin
                            if (empty)
                            begin
                                status_next = bol_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                state_next = bol_pkg::S_FIX;
                            end
                        end
                        bol_pkg::CMD_DEL_POS:
                        begin
                            if (empty || (pos_w == '0) || (pos_w > cnt_w))
                            begin
                                status_next = bol_pkg::ST_INVALID;
                            end
                            else
                            begin
                                left_next    = CW'(SW'(count_reg) - idx_s - SW'(1));
                                dst_ptr_next = idx_phys;
                                src_ptr_next = ptr_inc(idx_phys);
                                up_next      = 1'b1;
                                state_next   = bol_pkg::S_COPY;
                            end
                        end
                        bol_pkg::CMD_SEARCH:
                        begin
                            if (empty)
                            begin
                                status_next = bol_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                src_ptr_next = head_reg;
                                left_next    = count_reg;
                                state_next   = bol_pkg::S_SEARCH;
                            end
                        end
                        bol_pkg::CMD_ROTATE:
                        begin
                            if (empty)
                            begin
                                status_next = bol_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                mod_start  = 1'b1;
                                state_next = bol_pkg::S_MOD;
                            end
                        end
                        bol_pkg::CMD_DUMP:
                        begin
                            if (empty)
                            begin
                                status_next = bol_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                src_ptr_next = head_reg;
                                state_next   = bol_pkg::S_DUMP_RD;
                            end
                        end
                        default:
                        begin
                            status_next = bol_pkg::ST_INVALID;
                        end
                    endcase
                end
            end

            bol_pkg::S_MOD:
            begin
                if (mod_done)
                begin
                    // rotate right by k: move the last k words in front of the head
                    left_next    = mod_rem;
                    src_ptr_next = ptr_dec(tail_phys);
                    dst_ptr_next = ptr_dec(head_reg);
                    up_next      = 1'b0;
                    state_next   = bol_pkg::S_COPY;
                end
            end

            bol_pkg::S_COPY:
            begin
                // read one word a cycle, write it back the cycle after
                if (wr_pend_reg)
                begin
                    mem_wr_en = 1'b1;
                end
                if (left_reg != '0)
                begin
                    mem_rd_en     = 1'b1;
                    pend_dst_next = dst_ptr_reg;
                    wr_pend_next  = 1'b1;
                    src_ptr_next  = up_reg ? ptr_inc(src_ptr_reg) : ptr_dec(src_ptr_reg);
                    dst_ptr_next  = up_reg ? ptr_inc(dst_ptr_reg) : ptr_dec(dst_ptr_reg);
                    left_next     = left_reg - CW'(1);
                end
                else
                begin
                    wr_pend_next = 1'b0;
                    if (!wr_pend_reg)
                    begin
                        state_next = bol_pkg::S_FIX;
                    end
                end
            end

            bol_pkg::S_FIX:
            begin
                mem_wr_data = val_reg;
                status_next = bol_pkg::ST_OK;
                state_next  = bol_pkg::S_RESP;
                case (op_reg)
                    bol_pkg::CMD_INS_FRONT:
                    begin
                        head_next   = ptr_dec(head_reg);
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = ptr_dec(head_reg);
                        count_next  = count_reg + CW'(1);
                    end
                    bol_pkg::CMD_INS_END:
                    begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = tail_phys;
                        count_next  = count_reg + CW'(1);
                    end
                    bol_pkg::CMD_INS_POS:
                    begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = fix_phys;
                        count_next  = count_reg + CW'(1);
                    end
                    bol_pkg::CMD_DEL_FRONT:
                    begin
                        head_next  = ptr_inc(head_reg);
                        count_next = count_reg - CW'(1);
                    end
                    bol_pkg::CMD_DEL_END,
                    bol_pkg::CMD_DEL_POS:
                    begin
                        count_next = count_reg - CW'(1);
                    end
                    bol_pkg::CMD_ROTATE:
                    begin
                        head_next = ptr_inc(dst_ptr_reg);
                    end
                    default:
                    begin
                        head_next = head_reg;
                    end
                endcase
            end

            bol_pkg::S_SEARCH:
            begin
                if (chk_reg && (mem_rd_data == val_reg))
                begin
                    // rd_cnt counts reads issued, so it is the 1-based match position
                    status_next = bol_pkg::ST_OK;
                    fpos_next   = bol_pkg::POS_W'(rd_cnt_reg);
                    chk_next    = 1'b0;
                    state_next  = bol_pkg::S_RESP;
                end
                else if (left_reg != '0)
                begin
                    mem_rd_en    = 1'b1;
                    chk_next     = 1'b1;
                    src_ptr_next = ptr_inc(src_ptr_reg);
                    left_next    = left_reg - CW'(1);
                    rd_cnt_next  = rd_cnt_reg + CW'(1);
                end
                else
                begin
                    status_next = bol_pkg::ST_NOTFOUND;
                    fpos_next   = '0;
                    chk_next    = 1'b0;
                    state_next  = bol_pkg::S_RESP;
                end
            end

            bol_pkg::S_DUMP_RD:
            begin
                mem_rd_en    = 1'b1;
                src_ptr_next = ptr_inc(src_ptr_reg);
                rd_cnt_next  = rd_cnt_reg + CW'(1);
                state_next   = bol_pkg::S_DUMP_WAIT;
            end

            bol_pkg::S_DUMP_WAIT:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next         = 1'b1;
                    rsp_next.status        = bol_pkg::ST_OK;
                    rsp_next.found_position = '0;
                    rsp_next.element_value = mem_rd_data;
                    rsp_next.element_count = bol_pkg::CNT_OUT_W'(count_reg);
                    rsp_next.last_of_run   = (rd_cnt_reg == count_reg);
                    state_next = (rd_cnt_reg == count_reg) ? bol_pkg::S_IDLE
                                                           : bol_pkg::S_DUMP_RD;
                end
            end

            bol_pkg::S_RESP:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next         = 1'b1;
                    rsp_next.status        = status_reg;
                    rsp_next.found_position = fpos_reg;
                    rsp_next.element_value = '0;
                    rsp_next.element_count = bol_pkg::CNT_OUT_W'(count_reg);
                    rsp_next.last_of_run   = 1'b1;
                    state_next = bol_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = bol_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bol_pkg::S_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            wr_pend_reg   <= 1'b0;
            chk_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            wr_pend_reg   <= wr_pend_next;
            chk_reg       <= chk_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        val_reg      <= val_next;
        idx_reg      <= idx_next;
        src_ptr_reg  <= src_ptr_next;
        dst_ptr_reg  <= dst_ptr_next;
        pend_dst_reg <= pend_dst_next;
        up_reg       <= up_next;
        left_reg     <= left_next;
        rd_cnt_reg   <= rd_cnt_next;
        status_reg   <= status_next;
        fpos_reg     <= fpos_next;
        rsp_reg      <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIST_DEPTH = bol_pkg::DEPTH_DEF;
    localparam logic [bol_pkg::CMD_W-1:0] CMD_TOP_CODE = '1;
    localparam int RANDOM_COMMANDS = 245;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              req_valid = 1'b0;
    logic              req_ready;
    bol_pkg::bol_req_t req = '0;
    logic              rsp_valid;
    logic              rsp_ready = 1'b0;
    bol_pkg::bol_rsp_t rsp;

    bounded_ordered_list #(.DEPTH(LIST_DEPTH)) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    class list_scoreboard;
        logic signed [bol_pkg::DATA_W-1:0] slots [LIST_DEPTH];
        int                                live;
        bol_pkg::bol_rsp_t                 pending_words [$];
        int                                mismatches;

        function new();
            live = 0;
            mismatches = 0;
        endfunction

        function void push_word(bol_pkg::status_t st, logic [bol_pkg::POS_W-1:0] fpos,
                                logic signed [bol_pkg::DATA_W-1:0] value, logic last);
            bol_pkg::bol_rsp_t w;
            w.status         = st;
            w.found_position = fpos;
            w.element_value  = value;
            w.element_count  = bol_pkg::CNT_OUT_W'(live);
            w.last_of_run    = last;
            pending_words.push_back(w);
        endfunction

        function void open_gap(int idx, logic signed [bol_pkg::DATA_W-1:0] value);
            for (int i = live; i > idx; i--)
                slots[i] = slots[i-1];
            slots[idx] = value;
            live++;
        endfunction

        function void close_gap(int idx);
            for (int i = idx; i + 1 < live; i++)
                slots[i] = slots[i+1];
            live--;
        endfunction

        // works out every word that one accepted command should produce
        function void note_command(bol_pkg::bol_req_t c);
            logic signed [bol_pkg::DATA_W-1:0] spun [LIST_DEPTH];
            bol_pkg::status_t                  st;
            logic [bol_pkg::POS_W-1:0]         fpos;
            int                                k;
            int                                pos;
            st   = bol_pkg::ST_OK;
            fpos = '0;
            pos  = int'(c.position);
            case (c.cmd)
                bol_pkg::CMD_INS_FRONT, bol_pkg::CMD_INS_END:
                    if (live >= LIST_DEPTH)
                        st = bol_pkg::ST_FULL;
                    else
                        open_gap((c.cmd == bol_pkg::CMD_INS_FRONT) ? 0 : live,
                                 c.data_value);
                bol_pkg::CMD_INS_POS:
                    if (live >= LIST_DEPTH || pos < 1 || pos > live + 1)
                        st = bol_pkg::ST_INVALID;
                    else
                        open_gap(pos - 1, c.data_value);
                bol_pkg::CMD_DEL_FRONT, bol_pkg::CMD_DEL_END:
                    if (live == 0)
                        st = bol_pkg::ST_EMPTY;
                    else
                        close_gap((c.cmd == bol_pkg::CMD_DEL_FRONT) ? 0 : live - 1);
                bol_pkg::CMD_DEL_POS:
                    if (live == 0 || pos < 1 || pos > live)
                        st = bol_pkg::ST_INVALID;
                    else
                        close_gap(pos - 1);
                bol_pkg::CMD_SEARCH:
                    if (live == 0)
                        st = bol_pkg::ST_EMPTY;
                    else
                    begin
                        st = bol_pkg::ST_NOTFOUND;
                        for (int i = 0; i < live; i++)
                            if (st == bol_pkg::ST_NOTFOUND && slots[i] == c.data_value)
                            begin
                                st   = bol_pkg::ST_OK;
                                fpos = bol_pkg::POS_W'(i + 1);
                            end
                    end
                bol_pkg::CMD_ROTATE:
                    if (live == 0)
                        st = bol_pkg::ST_EMPTY;
                    else
                    begin
                        k = int'(c.rotate_amount) % live;
                        for (int i = 0; i < live; i++)
                            spun[(i + k) % live] = slots[i];
                        for (int i = 0; i < live; i++)
                            slots[i] = spun[i];
                    end
                bol_pkg::CMD_DUMP:
                    if (live == 0)
                        st = bol_pkg::ST_EMPTY;
                    else
                    begin
                        for (int i = 0; i < live; i++)
                            push_word(bol_pkg::ST_OK, '0, slots[i], i + 1 == live);
                        return;
                    end
                default:
                    st = bol_pkg::ST_INVALID;
            endcase
            push_word(st, fpos, '0, 1'b1);
        endfunction

        function void report_field(string what, logic [bol_pkg::DATA_W-1:0] want,
                                   logic [bol_pkg::DATA_W-1:0] got);
            if (want !== got)
            begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
                mismatches++;
            end
        endfunction

        function void check_word(bol_pkg::bol_rsp_t got);
            bol_pkg::bol_rsp_t want;
            if (pending_words.size() == 0)
            begin
                $display("%0t: unexpected word, expected none, actual %h", $time, got);
                mismatches++;
                return;
            end
            want = pending_words.pop_front();
            report_field("status", bol_pkg::DATA_W'(want.status),
                         bol_pkg::DATA_W'(got.status));
            report_field("found_position", bol_pkg::DATA_W'(want.found_position),
                         bol_pkg::DATA_W'(got.found_position));
            report_field("element_value", want.element_value, got.element_value);
            report_field("element_count", bol_pkg::DATA_W'(want.element_count),
                         bol_pkg::DATA_W'(got.element_count));
            report_field("last_of_run", bol_pkg::DATA_W'(want.last_of_run),
                         bol_pkg::DATA_W'(got.last_of_run));
        endfunction
    endclass

    list_scoreboard sb = new();

    logic [bol_pkg::CMD_W-1:0] cmd_menu [9] = '{
        bol_pkg::CMD_INS_FRONT, bol_pkg::CMD_INS_END, bol_pkg::CMD_INS_POS,
        bol_pkg::CMD_DEL_FRONT, bol_pkg::CMD_DEL_END, bol_pkg::CMD_DEL_POS,
        bol_pkg::CMD_SEARCH, bol_pkg::CMD_ROTATE, bol_pkg::CMD_DUMP};
    // last weight is for the unused codes
    int unsigned grow_weights [10]   = '{20, 20, 20, 6, 4, 4, 8, 7, 6, 5};
    int unsigned shrink_weights [10] = '{6, 4, 4, 20, 18, 20, 8, 7, 7, 6};

    int burst_left = 0;

    initial
    begin
        forever #10 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    // receiver stall pattern, changing its character every so often
    initial
    begin
        int stall_mode;
        int cyc;
        stall_mode = 0;
        cyc = 0;
        forever
        begin
            @(negedge clk);
            cyc++;
            if (cyc % 150 == 0)
                stall_mode = $urandom_range(0, 2);
            case (stall_mode)
                0: rsp_ready <= 1'b1;
                1: rsp_ready <= ($urandom_range(0, 99) < 60);
                default: rsp_ready <= (cyc % 5) > 1;
            endcase
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_valid && rsp_ready)
                sb.check_word(rsp);
        end
    end

    task automatic send_command(input bol_pkg::bol_req_t c);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0)
            begin
                gap = $urandom_range(1, 10);
                @(negedge clk);
                req_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        req       <= c;
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
        sb.note_command(c);
    endtask

    task automatic issue(input logic [bol_pkg::CMD_W-1:0] cmd,
                         input logic signed [bol_pkg::DATA_W-1:0] value,
                         input logic [bol_pkg::POS_W-1:0] pos,
                         input logic [bol_pkg::AMT_W-1:0] amount);
        bol_pkg::bol_req_t c;
        c.cmd           = cmd;
        c.data_value    = value;
        c.position      = pos;
        c.rotate_amount = amount;
        send_command(c);
    endtask

    function automatic bol_pkg::bol_req_t random_command(bit grow);
        bol_pkg::bol_req_t c;
        int unsigned       roll;
        int unsigned       acc;
        int                pick;
        int                n;
        n    = sb.live;
        roll = $urandom_range(0, 99);
        acc  = 0;
        pick = 9;
        for (int i = 0; i < 10; i++)
        begin
            acc += grow ? grow_weights[i] : shrink_weights[i];
            if (pick == 9 && roll < acc)
                pick = i;
        end
        if (pick == 9)
            c.cmd = CMD_TOP_CODE - bol_pkg::CMD_W'($urandom_range(0,
                                       CMD_TOP_CODE - bol_pkg::CMD_DUMP - 1));
        else
            c.cmd = cmd_menu[pick];

        c.position = bol_pkg::POS_W'($urandom);
        if ($urandom_range(0, 99) < 85)
        begin
            if (c.cmd == bol_pkg::CMD_INS_POS)
                c.position = bol_pkg::POS_W'($urandom_range(1, n + 1));
            else if (c.cmd == bol_pkg::CMD_DEL_POS && n > 0)
                c.position = bol_pkg::POS_W'($urandom_range(1, n));
        end

        roll = $urandom_range(0, 99);
        c.data_value = $urandom;
        if (roll < 30 && n > 0)
            c.data_value = sb.slots[$urandom_range(0, n - 1)];
        else if (roll < 40)
            case ($urandom_range(0, 3))
                0: c.data_value = {1'b0, {(bol_pkg::DATA_W-1){1'b1}}};
                1: c.data_value = {1'b1, {(bol_pkg::DATA_W-1){1'b0}}};
                2: c.data_value = '0;
                default: c.data_value = '1;
            endcase

        roll = $urandom_range(0, 99);
        if (roll < 40)
            c.rotate_amount = bol_pkg::AMT_W'($urandom_range(0, 40));
        else if (roll < 55 && n > 0)
            c.rotate_amount = bol_pkg::AMT_W'(n * $urandom_range(0, 100));
        else
            c.rotate_amount = bol_pkg::AMT_W'($urandom);
        return c;
    endfunction

    initial
    begin
        int waited;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // empty list
        issue(bol_pkg::CMD_DEL_FRONT, 0, 0, 0);
        issue(bol_pkg::CMD_DEL_END, 0, 0, 0);
        issue(bol_pkg::CMD_DEL_POS, 0, 1, 0);
        issue(bol_pkg::CMD_SEARCH, 0, 0, 0);
        issue(bol_pkg::CMD_ROTATE, 0, 0, 3);
        issue(bol_pkg::CMD_DUMP, 0, 0, 0);
        issue(bol_pkg::CMD_INS_POS, 5, 0, 0);
        issue(bol_pkg::CMD_INS_POS, 5, 2, 0);
        // build max, 0, min, -1
        issue(bol_pkg::CMD_INS_FRONT, 32'sh7fff_ffff, 0, 0);
        issue(bol_pkg::CMD_INS_END, 32'sh8000_0000, 0, 0);
        issue(bol_pkg::CMD_INS_POS, 0, 2, 0);
        issue(bol_pkg::CMD_INS_POS, -1, 4, 0);
        issue(bol_pkg::CMD_SEARCH, 32'sh8000_0000, 0, 0);
        issue(bol_pkg::CMD_SEARCH, 12345, 0, 0);
        issue(bol_pkg::CMD_ROTATE, 0, 0, 16'hffff);
        issue(bol_pkg::CMD_ROTATE, 0, 0, 8);
        issue(bol_pkg::CMD_DUMP, 0, 0, 0);
        issue(bol_pkg::CMD_DEL_POS, 0, 0, 0);
        issue(bol_pkg::CMD_DEL_POS, 0, 31, 0);
        issue(bol_pkg::CMD_DEL_POS, 0, 5, 0);
        issue(bol_pkg::CMD_DEL_POS, 0, 2, 0);
        issue(bol_pkg::CMD_DUMP + bol_pkg::CMD_W'(1), 0, 0, 0);
        issue(CMD_TOP_CODE, '1, '1, '1);
        issue(bol_pkg::CMD_DEL_FRONT, 0, 0, 0);
        issue(bol_pkg::CMD_DEL_END, 0, 0, 0);

        // alternate filling and draining phases so full and empty are both reached
        for (int it = 0; it < RANDOM_COMMANDS; it++)
            send_command(random_command(((it / 40) % 2) == 0));

        @(negedge clk);
        req_valid <= 1'b0;

        waited = 0;
        while (sb.pending_words.size() != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (60) @(posedge clk);

        if (sb.mismatches == 0 && sb.pending_words.size() == 0)
            $display("tb: success");
        else
        begin
            if (sb.pending_words.size() != 0)
                $display("%0t: %0d expected words never arrived", $time,
                         sb.pending_words.size());
            $display("tb: failure");
        end
        $finish;
    end
endmodule
